// File: rtl/core/multi_led_blink_timer_core_macros.svh
// Assertion macros for the LED blink timer core.
// Bodies drop out when SYNTH is defined; no other dependencies.
`ifndef MULTI_LED_BLINK_TIMER_CORE_MACROS_SVH
`define MULTI_LED_BLINK_TIMER_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising edge out of reset.
`define MLBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define MLBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define MLBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define MLBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/core/mlbt_pkg.sv
// Shared types and codes for the LED blink timer core.
// No dependencies.
package mlbt_pkg;

	localparam int CNT_W  = 14;
	localparam int MASK_W = 14;
	localparam int LEN_W  = 16;

	localparam logic [CNT_W-1:0] CNT_MAX = 14'h3FFF;

	// action codes
	localparam logic ACT_SET  = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// mode codes
	localparam logic [1:0] MODE_OFF   = 2'd0;
	localparam logic [1:0] MODE_ON    = 2'd1;
	localparam logic [1:0] MODE_FLASH = 2'd2;

	typedef struct packed {
		logic             action;
		logic [3:0]       led_index;
		logic [1:0]       chan_mode;
		logic [LEN_W-1:0] on_length;
		logic [LEN_W-1:0] off_length;
		logic [LEN_W-1:0] life_length;
	} cmd_item_t;

	typedef struct packed {
		logic [MASK_W-1:0] lit_mask;
		logic              timer_running;
	} rsp_item_t;

	// per-channel control from the top level
	typedef struct packed {
		logic             set_en;
		logic             flash;
		logic             lit_on;
		logic             tick_en;
		logic [CNT_W-1:0] on_ticks;
		logic [CNT_W-1:0] off_ticks;
		logic [CNT_W-1:0] life_ticks;
	} chan_ctl_t;

	// per-channel status back to the top level
	typedef struct packed {
		logic lit_d;
		logic busy;
	} chan_sts_t;

endpackage

// File: rtl/core/mlbt_scale.sv
// Divide a 16-bit length by a constant and saturate to the counter width.
// Depends on mlbt_pkg.
module mlbt_scale #(
	parameter int DIVISOR = 5
) (
	input  logic [mlbt_pkg::LEN_W-1:0] raw,
	output logic [mlbt_pkg::CNT_W-1:0] scaled
);

	// ceil(2^32 / DIVISOR) gives an exact quotient for any 16-bit dividend
	localparam int SHIFT = 32;
	localparam longint unsigned RECIP_L =
		((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [SHIFT:0] RECIP = (SHIFT+1)'(RECIP_L);
	localparam int PROD_W = mlbt_pkg::LEN_W + SHIFT + 1;

	logic [PROD_W-1:0]          prod;
	logic [mlbt_pkg::LEN_W-1:0] quo;

	assign prod = PROD_W'(raw) * PROD_W'(RECIP);
	assign quo  = prod[SHIFT +: mlbt_pkg::LEN_W];

	always_comb begin
		if (quo > mlbt_pkg::LEN_W'(mlbt_pkg::CNT_MAX)) begin
			scaled = mlbt_pkg::CNT_MAX;
		end else begin
			scaled = quo[mlbt_pkg::CNT_W-1:0];
		end
	end

endmodule

// File: rtl/core/mlbt_chan.sv
// One LED channel: lit flag, on/off lengths, life and phase counters.
// Depends on mlbt_pkg.
module mlbt_chan (
	input  logic                clk,
	input  logic                arst_n,
	input  mlbt_pkg::chan_ctl_t ctl,
	output mlbt_pkg::chan_sts_t sts
);

	logic                       lit_q, lit_d;
	logic [mlbt_pkg::CNT_W-1:0] on_q, on_d;
	logic [mlbt_pkg::CNT_W-1:0] off_q, off_d;
	logic [mlbt_pkg::CNT_W-1:0] life_q, life_d;
	logic [mlbt_pkg::CNT_W-1:0] phase_q, phase_d;
	logic [mlbt_pkg::CNT_W-1:0] life_dec, phase_dec;
	logic                       busy;

	assign life_dec  = life_q - 1'b1;
	assign phase_dec = phase_q - 1'b1;

	always_comb begin
		lit_d   = lit_q;
		on_d    = on_q;
		off_d   = off_q;
		life_d  = life_q;
		phase_d = phase_q;
		busy    = 1'b0;
		if (ctl.set_en) begin
			life_d = ctl.life_ticks;
			if (ctl.flash) begin
				lit_d   = 1'b1;
				on_d    = ctl.on_ticks;
				off_d   = ctl.off_ticks;
				phase_d = ctl.on_ticks;
			end else begin
				lit_d   = ctl.lit_on;
				on_d    = '0;
				off_d   = '0;
				phase_d = '0;
			end
		end else if (ctl.tick_en) begin
			if (life_q != '0 && life_dec == '0) begin
				// life ran out: force off, channel idle
				life_d  = '0;
				lit_d   = 1'b0;
				phase_d = '0;
			end else begin
				if (life_q != '0) begin
					life_d = life_dec;
					busy   = 1'b1;
				end
				if (phase_q != '0) begin
					busy = 1'b1;
					if (phase_dec == '0) begin
						phase_d = lit_q ? off_q : on_q;
						lit_d   = ~lit_q;
					end else begin
						phase_d = phase_dec;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q   <= 1'b0;
			on_q    <= '0;
			off_q   <= '0;
			life_q  <= '0;
			phase_q <= '0;
		end else begin
			lit_q   <= lit_d;
			on_q    <= on_d;
			off_q   <= off_d;
			life_q  <= life_d;
			phase_q <= phase_d;
		end
	end

	assign sts.lit_d = lit_d;
	assign sts.busy  = busy;

endmodule

// File: rtl/core/multi_led_blink_timer_core.sv
// Top level of the multi-channel LED blink timer core.
// Depends on mlbt_pkg, mlbt_scale, mlbt_chan and the core macros header.
//
// Usage:
//   The cmd channel (cmd_valid/cmd_ready/cmd) takes one beat per item: a set
//   beat programs one LED channel as off, on or flashing, a tick beat ages
//   every channel at once. Lengths are divided by TICK_DIVISOR on entry and
//   saturate to 14 bits. The rsp channel (rsp_valid/rsp_ready/rsp) returns
//   exactly one beat per cmd beat, in order, carrying the lit mask and the
//   timer state after that item; invalid sets and ticks with the timer
//   stopped still return the current state.
//   A cmd beat is held in the input register, and its rsp beat in the result
//   register. Throughput: one item per cycle while rsp_ready is high; the
//   divide is a constant multiply ahead of the input register and all channel
//   counters update in parallel in the second stage, so nothing loops.
//   Reset (arst_n low): all LEDs off, all counters zero, timer stopped, both
//   pipeline stages empty.
//   Stall: while rsp_ready is low the rsp beat holds; one more item waits in
//   the input register, after which cmd_ready drops until rsp moves.
`include "multi_led_blink_timer_core_macros.svh"

module multi_led_blink_timer_core #(
	parameter int LED_COUNT    = 14,
	parameter int TICK_DIVISOR = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  mlbt_pkg::cmd_item_t cmd,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output mlbt_pkg::rsp_item_t rsp
);

	// ---------------------------------------------------------------
	// Front end: decode and scale the incoming beat
	// ---------------------------------------------------------------
	logic                       in_set, in_tick, in_flash, in_lit_on;
	logic                       idx_ok, mode_ok, set_ok, start;
	logic                       on_nz, off_nz, life_nz;
	logic [mlbt_pkg::CNT_W-1:0] on_sc, off_sc, life_sc;

	assign in_set    = cmd.action == mlbt_pkg::ACT_SET;
	assign in_tick   = cmd.action == mlbt_pkg::ACT_TICK;
	assign in_flash  = cmd.chan_mode == mlbt_pkg::MODE_FLASH;
	assign in_lit_on = cmd.chan_mode == mlbt_pkg::MODE_ON;
	assign idx_ok    = 32'(cmd.led_index) < 32'(LED_COUNT);
	assign mode_ok   = (cmd.chan_mode == mlbt_pkg::MODE_OFF) ||
	                   (cmd.chan_mode == mlbt_pkg::MODE_ON) ||
	                   (cmd.chan_mode == mlbt_pkg::MODE_FLASH);
	assign on_nz     = cmd.on_length != '0;
	assign off_nz    = cmd.off_length != '0;
	assign life_nz   = cmd.life_length != '0;

	// flash needs both raw lengths; an unusable set changes nothing
	assign set_ok = in_set && idx_ok && mode_ok && (!in_flash || (on_nz && off_nz));
	// a steady set with life zero never wakes the timer
	assign start  = set_ok && (in_flash || life_nz);

	mlbt_scale #(.DIVISOR(TICK_DIVISOR)) u_scale_on (
		.raw    (cmd.on_length),
		.scaled (on_sc)
	);

	mlbt_scale #(.DIVISOR(TICK_DIVISOR)) u_scale_off (
		.raw    (cmd.off_length),
		.scaled (off_sc)
	);

	mlbt_scale #(.DIVISOR(TICK_DIVISOR)) u_scale_life (
		.raw    (cmd.life_length),
		.scaled (life_sc)
	);

	// ---------------------------------------------------------------
	// Input register
	// ---------------------------------------------------------------
	logic                       s1_valid;
	logic                       s1_tick, s1_set_ok, s1_start, s1_flash, s1_lit_on;
	logic [3:0]                 s1_idx;
	logic [mlbt_pkg::CNT_W-1:0] s1_on, s1_off, s1_life;
	logic                       cmd_fire, adv;
	logic                       rsp_valid_q;
	mlbt_pkg::rsp_item_t        rsp_q;

	// advance whenever the result register is free or being drained
	assign adv       = s1_valid && (!rsp_valid_q || rsp_ready);
	assign cmd_ready = !s1_valid || adv;
	assign cmd_fire  = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (cmd_ready) begin
			s1_valid <= cmd_valid;
		end
	end

	// payload: no reset
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			s1_tick   <= in_tick;
			s1_set_ok <= set_ok;
			s1_start  <= start;
			s1_flash  <= in_flash;
			s1_lit_on <= in_lit_on;
			s1_idx    <= cmd.led_index;
			s1_on     <= on_sc;
			s1_off    <= off_sc;
			s1_life   <= life_sc;
		end
	end

	// ---------------------------------------------------------------
	// Channel array and timer enable
	// ---------------------------------------------------------------
	logic                       timer_q, timer_d;
	logic                       tick_en;
	logic [LED_COUNT-1:0]       lit_vec, busy_vec;
	logic [mlbt_pkg::MASK_W-1:0] mask_d;

	// ticks only count while the timer runs
	assign tick_en = adv && s1_tick && timer_q;

	for (genvar i = 0; i < LED_COUNT; i++) begin : g_chan
		mlbt_pkg::chan_ctl_t ctl;
		mlbt_pkg::chan_sts_t sts;

		assign ctl.set_en     = adv && s1_set_ok && (32'(s1_idx) == 32'(i));
		assign ctl.flash      = s1_flash;
		assign ctl.lit_on     = s1_lit_on;
		assign ctl.tick_en    = tick_en;
		assign ctl.on_ticks   = s1_on;
		assign ctl.off_ticks  = s1_off;
		assign ctl.life_ticks = s1_life;

		mlbt_chan u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.sts    (sts)
		);

		assign lit_vec[i]  = sts.lit_d;
		assign busy_vec[i] = sts.busy;
	end

	// map channels onto the fixed-width mask; extra bits read as unlit
	for (genvar j = 0; j < mlbt_pkg::MASK_W; j++) begin : g_mask
		if (j < LED_COUNT) begin : g_used
			assign mask_d[j] = lit_vec[j];
		end else begin : g_unused
			assign mask_d[j] = 1'b0;
		end
	end

	always_comb begin
		priority if (adv && s1_start) begin
			timer_d = 1'b1;
		end else if (tick_en && !(|busy_vec)) begin
			// no channel left busy: stop
			timer_d = 1'b0;
		end else begin
			timer_d = timer_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= 1'b0;
		end else begin
			timer_q <= timer_d;
		end
	end

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.lit_mask      <= mask_d;
			rsp_q.timer_running <= timer_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`MLBT_ASSERT_NXT(a_adv_gives_rsp, clk, arst_n, adv, rsp_valid_q, "advance without rsp beat")
	`MLBT_ASSERT_NXT(a_start_runs, clk, arst_n, adv && s1_start, timer_q, "timer not started")
	`MLBT_ASSERT_NXT(a_stopped_tick, clk, arst_n, adv && s1_tick && !timer_q, !timer_q, "tick woke timer")
	`MLBT_ASSERT_IMP(a_rsp_timer_match, clk, arst_n, rsp_valid_q, rsp_q.timer_running == timer_q, "stale timer bit")
	`MLBT_ASSERT_NXT(a_no_extra_rsp, clk, arst_n, rsp_valid_q && rsp_ready && !adv, !rsp_valid_q, "rsp beat repeated")

endmodule

// File: verif/multi_led_blink_timer_core_test.sv
// Testbench for the multi-channel LED blink timer core: drives set and tick beats,
// predicts the lit mask and timer state per beat and checks every rsp beat in order.
// Depends on mlbt_pkg and multi_led_blink_timer_core.
module multi_led_blink_timer_core_test;

	localparam int LEDS        = 14;
	localparam int TICK_DIV    = 5;
	localparam int HOLD_CYCLES = 80;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 10;

	// mode code with no meaning; the block must ignore it
	localparam logic [1:0] MODE_BAD = 2'd3;

	typedef logic [mlbt_pkg::CNT_W-1:0] cnt_t;
	typedef logic [mlbt_pkg::LEN_W-1:0] len_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cmd_valid = 1'b0;
	logic                cmd_ready;
	mlbt_pkg::cmd_item_t cmd = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	mlbt_pkg::rsp_item_t rsp;

	// predicted channel state
	logic lamp_lit  [LEDS] = '{default: 1'b0};
	cnt_t on_len    [LEDS] = '{default: '0};
	cnt_t off_len   [LEDS] = '{default: '0};
	cnt_t life_left [LEDS] = '{default: '0};
	cnt_t phase_left[LEDS] = '{default: '0};
	logic tmr_run = 1'b0;

	mlbt_pkg::rsp_item_t expected_q[$];

	int err_cnt       = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left     = 0;
	bit hold_req      = 1'b0;
	bit hold_taken    = 1'b0;
	int quiet_cycles  = 0;

	multi_led_blink_timer_core #(
		.LED_COUNT   (LEDS),
		.TICK_DIVISOR(TICK_DIV)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Divide a raw length down to ticks and clamp to the counter width.
	function automatic cnt_t to_ticks(input len_t raw);
		len_t q;
		q = mlbt_pkg::LEN_W'(raw / mlbt_pkg::LEN_W'(TICK_DIV));
		return (q > mlbt_pkg::LEN_W'(mlbt_pkg::CNT_MAX)) ? mlbt_pkg::CNT_MAX
		                                                 : q[mlbt_pkg::CNT_W-1:0];
	endfunction

	// Program one channel; unusable sets change nothing.
	function automatic void program_channel(input mlbt_pkg::cmd_item_t it);
		int ch;
		bit start;
		ch    = int'(it.led_index);
		start = 1'b0;
		if (ch >= LEDS || it.chan_mode == MODE_BAD)
			return;
		if (it.chan_mode == mlbt_pkg::MODE_FLASH) begin
			// flash with either length zero is dropped
			if (it.on_length == '0 || it.off_length == '0)
				return;
			lamp_lit[ch]   = 1'b1;
			on_len[ch]     = to_ticks(it.on_length);
			off_len[ch]    = to_ticks(it.off_length);
			life_left[ch]  = to_ticks(it.life_length);
			phase_left[ch] = to_ticks(it.on_length);
			start          = 1'b1;
		end else begin
			on_len[ch]     = '0;
			off_len[ch]    = '0;
			life_left[ch]  = to_ticks(it.life_length);
			phase_left[ch] = '0;
			lamp_lit[ch]   = (it.chan_mode == mlbt_pkg::MODE_ON);
			start          = (it.life_length != '0);
		end
		if (start)
			tmr_run = 1'b1;
	endfunction

	// Age every channel by one tick while the timer runs.
	function automatic void age_channels();
		bit busy;
		busy = 1'b0;
		if (!tmr_run)
			return;
		for (int i = 0; i < LEDS; i++) begin
			if (life_left[i] != '0) begin
				life_left[i]--;
				if (life_left[i] == '0) begin
					// life over: force off, channel not busy on this tick
					lamp_lit[i]   = 1'b0;
					phase_left[i] = '0;
					continue;
				end
				busy = 1'b1;
			end
			if (phase_left[i] != '0) begin
				phase_left[i]--;
				if (phase_left[i] == '0) begin
					phase_left[i] = lamp_lit[i] ? off_len[i] : on_len[i];
					lamp_lit[i]   = !lamp_lit[i];
				end
				busy = 1'b1;
			end
		end
		if (!busy)
			tmr_run = 1'b0;
	endfunction

	function automatic mlbt_pkg::rsp_item_t predict_beat(input mlbt_pkg::cmd_item_t it);
		mlbt_pkg::rsp_item_t want;
		want = '0;
		if (it.action == mlbt_pkg::ACT_TICK)
			age_channels();
		else
			program_channel(it);
		for (int i = 0; i < LEDS; i++)
			want.lit_mask[i] = lamp_lit[i];
		want.timer_running = tmr_run;
		return want;
	endfunction

	// ------------------------------------------------------------------
	// Beat helpers
	// ------------------------------------------------------------------

	// Offer one cmd beat, hold it until taken, then queue its prediction.
	task automatic send_beat(input mlbt_pkg::cmd_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= it;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		expected_q.push_back(predict_beat(it));
	endtask

	task automatic set_beat(input int ch, input logic [1:0] mode, input logic [15:0] on_l,
	                        input logic [15:0] off_l, input logic [15:0] life_l);
		mlbt_pkg::cmd_item_t it;
		it             = '0;
		it.action      = mlbt_pkg::ACT_SET;
		it.led_index   = 4'(ch);
		it.chan_mode   = mode;
		it.on_length   = on_l;
		it.off_length  = off_l;
		it.life_length = life_l;
		send_beat(it);
	endtask

	task automatic tick_beat(input int n);
		mlbt_pkg::cmd_item_t it;
		it        = '0;
		it.action = mlbt_pkg::ACT_TICK;
		repeat (n)
			send_beat(it);
	endtask

	// Drop valid and wait until every predicted rsp beat has arrived.
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_q.size() != 0);
	endtask

	// Mostly short lengths so channels toggle and expire within a few ticks.
	function automatic logic [15:0] pick_length();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		else if (r == 1)
			return 16'($urandom_range(1, TICK_DIV - 1));
		else if (r == 2)
			return 16'($urandom());
		return 16'($urandom_range(TICK_DIV, 60));
	endfunction

	function automatic mlbt_pkg::cmd_item_t rand_beat();
		mlbt_pkg::cmd_item_t it;
		int                  r;
		it.action    = ($urandom_range(0, 99) < 55) ? mlbt_pkg::ACT_TICK : mlbt_pkg::ACT_SET;
		it.led_index = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(LEDS, 15))
		                                           : 4'($urandom_range(0, LEDS - 1));
		r = $urandom_range(0, 19);
		if (r == 0)
			it.chan_mode = MODE_BAD;
		else if (r < 5)
			it.chan_mode = mlbt_pkg::MODE_OFF;
		else if (r < 8)
			it.chan_mode = mlbt_pkg::MODE_ON;
		else
			it.chan_mode = mlbt_pkg::MODE_FLASH;
		it.on_length   = pick_length();
		it.off_length  = pick_length();
		it.life_length = pick_length();
		return it;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Sets that must be dropped, and a tick while the timer is stopped.
	task automatic test_ignored_items();
		tick_beat(1);
		set_beat(LEDS, mlbt_pkg::MODE_ON, 16'd10, 16'd10, 16'd10);
		set_beat(15, mlbt_pkg::MODE_FLASH, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		set_beat(2, MODE_BAD, 16'd10, 16'd10, 16'd10);
		set_beat(3, mlbt_pkg::MODE_FLASH, 16'd0, 16'd10, 16'd0);
		set_beat(3, mlbt_pkg::MODE_FLASH, 16'd10, 16'd0, 16'd0);
	endtask

	// Every mode, the edge channels and the length extremes.
	task automatic test_channel_modes();
		set_beat(0, mlbt_pkg::MODE_ON, 16'd0, 16'd0, 16'd0);
		set_beat(LEDS - 1, mlbt_pkg::MODE_OFF, 16'd0, 16'd0, 16'd0);
		set_beat(LEDS - 1, mlbt_pkg::MODE_ON, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		set_beat(1, mlbt_pkg::MODE_FLASH, 16'd10, 16'd15, 16'd0);
		// lengths below the divisor give a zero phase that never toggles
		set_beat(7, mlbt_pkg::MODE_FLASH, 16'd4, 16'd4, 16'd0);
		set_beat(12, mlbt_pkg::MODE_FLASH, 16'hFFFF, 16'hFFFF, 16'hFFFF);
	endtask

	// Life expiry, phase toggling and the timer stopping once nothing is busy.
	task automatic test_tick_aging();
		set_beat(5, mlbt_pkg::MODE_ON, 16'd0, 16'd0, 16'd10);
		tick_beat(5);
		set_beat(1, mlbt_pkg::MODE_OFF, 16'd0, 16'd0, 16'd0);
		set_beat(12, mlbt_pkg::MODE_OFF, 16'd0, 16'd0, 16'd0);
		set_beat(LEDS - 1, mlbt_pkg::MODE_OFF, 16'd0, 16'd0, 16'd0);
		tick_beat(2);
	endtask

	task automatic test_random_traffic(input int n, input int s_pct, input int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		repeat (n)
			send_beat(rand_beat());
		wait_drained();
	endtask

	// Hold rsp off for a long stretch while cmd beats keep coming.
	task automatic test_stall_fill();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req      = 1'b1;
		repeat (30)
			send_beat(rand_beat());
		wait_drained();
		hold_req      = 1'b0;
	endtask

	// Pause the sender mid-stream until every rsp beat is back.
	task automatic test_drain_pause();
		send_idle_pct = 10;
		recv_idle_pct = 30;
		repeat (20)
			send_beat(rand_beat());
		wait_drained();
		repeat (20)
			send_beat(rand_beat());
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// Response side
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		$display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
		err_cnt++;
	endtask

	// Drive rsp_ready: random stalls, or a counted hold-off when requested.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = HOLD_CYCLES;
			end else if (!hold_req) begin
				hold_taken = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Compare each rsp beat with the oldest prediction.
	always @(posedge clk) begin
		mlbt_pkg::rsp_item_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected rsp beat, lit_mask", 32'(rsp.lit_mask), '0);
			end else begin
				want = expected_q.pop_front();
				if (rsp.lit_mask !== want.lit_mask)
					report_mismatch("lit_mask", 32'(rsp.lit_mask), 32'(want.lit_mask));
				if (rsp.timer_running !== want.timer_running)
					report_mismatch("timer_running", 32'(rsp.timer_running),
					                32'(want.timer_running));
			end
		end
	end

	// Count cycles with no beat on either side; give up past the limit.
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ignored_items();
		test_channel_modes();
		test_tick_aging();
		wait_drained();

		test_random_traffic(220, 21, 69);
		test_random_traffic(220, 69, 21);
		test_random_traffic(220, 0, 0);
		test_stall_fill();
		test_drain_pause();

		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (err_cnt == 0 && expected_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
